[hdl/snapshot_ring_bracket_search_top_macros.svh]
// Assertion macros shared by the snapshot ring bracket search RTL.
// Included by files that check their own logic; needs no package.
`ifndef SNAPSHOT_RING_BRACKET_SEARCH_TOP_MACROS_SVH
`define SNAPSHOT_RING_BRACKET_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SRBS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srbs check failed");
`define SRBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srbs check failed");
`else
`define SRBS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SRBS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/srbs_pkg.sv]
// Shared types, constants and the microcode program of the snapshot ring.
// No dependencies; used by srbs_useq and snapshot_ring_bracket_search_top.
`timescale 1ns / 1ps
`default_nettype none
package srbs_pkg;

    localparam int DEPTH      = 16;
    localparam int FRAC_BITS  = 16;
    localparam int TICK_W     = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int BITCNT_W   = $clog2(FRAC_BITS + 1);

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    typedef logic [3:0] act_t;
    typedef logic [3:0] cond_t;
    typedef logic [3:0] step_t;

    localparam act_t ACT_NONE      = 4'd0;
    localparam act_t ACT_ACCEPT    = 4'd1;
    localparam act_t ACT_WALK_INIT = 4'd2;
    localparam act_t ACT_READ      = 4'd3;
    localparam act_t ACT_COMPARE   = 4'd4;
    localparam act_t ACT_DIV_INIT  = 4'd5;
    localparam act_t ACT_DIV_STEP  = 4'd6;
    localparam act_t ACT_EMIT      = 4'd7;
    localparam act_t ACT_PUSH      = 4'd8;

    localparam cond_t COND_NEVER     = 4'd0;
    localparam cond_t COND_ALWAYS    = 4'd1;
    localparam cond_t COND_NO_REQ    = 4'd2;
    localparam cond_t COND_PUSH      = 4'd3;
    localparam cond_t COND_FEW       = 4'd4;
    localparam cond_t COND_WALK_MORE = 4'd5;
    localparam cond_t COND_NO_PAIR   = 4'd6;
    localparam cond_t COND_DIV_MORE  = 4'd7;
    localparam cond_t COND_OUT_FREE  = 4'd8;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DECODE   = 4'd1;
    localparam step_t STEP_WALK     = 4'd2;
    localparam step_t STEP_READ     = 4'd3;
    localparam step_t STEP_COMPARE  = 4'd4;
    localparam step_t STEP_DIV_INIT = 4'd5;
    localparam step_t STEP_DIV      = 4'd6;
    localparam step_t STEP_EMIT     = 4'd7;
    localparam step_t STEP_RETRY    = 4'd8;
    localparam step_t STEP_PUSH     = 4'd9;
    localparam step_t STEP_LAST     = STEP_PUSH;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_req;
        logic is_push;
        logic few;
        logic walk_more;
        logic no_pair;
        logic div_more;
        logic out_free;
    } cond_flags_t;

    // Fall-through goes to the next step; a true condition jumps to target.
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_IDLE:     w = '{ACT_ACCEPT,    COND_NO_REQ,    STEP_IDLE};
            STEP_DECODE:   w = '{ACT_NONE,      COND_PUSH,      STEP_PUSH};
            STEP_WALK:     w = '{ACT_WALK_INIT, COND_FEW,       STEP_EMIT};
            STEP_READ:     w = '{ACT_READ,      COND_NEVER,     STEP_IDLE};
            STEP_COMPARE:  w = '{ACT_COMPARE,   COND_WALK_MORE, STEP_READ};
            STEP_DIV_INIT: w = '{ACT_DIV_INIT,  COND_NO_PAIR,   STEP_EMIT};
            STEP_DIV:      w = '{ACT_DIV_STEP,  COND_DIV_MORE,  STEP_DIV};
            STEP_EMIT:     w = '{ACT_EMIT,      COND_OUT_FREE,  STEP_IDLE};
            STEP_RETRY:    w = '{ACT_NONE,      COND_ALWAYS,    STEP_EMIT};
            STEP_PUSH:     w = '{ACT_PUSH,      COND_ALWAYS,    STEP_EMIT};
            default:       w = '{ACT_NONE,      COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[hdl/srbs_useq.sv]
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on srbs_pkg for the control word, condition codes and program.
`timescale 1ns / 1ps
`default_nettype none
module srbs_useq (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire srbs_pkg::cond_flags_t    flags,
    output srbs_pkg::ctrl_word_t          ctrl
);

    srbs_pkg::step_t pc_reg;
    srbs_pkg::step_t pc_next;
    logic            take;

    assign ctrl = srbs_pkg::ucode_rom(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            srbs_pkg::COND_NEVER:     take = 1'b0;
            srbs_pkg::COND_ALWAYS:    take = 1'b1;
            srbs_pkg::COND_NO_REQ:    take = flags.no_req;
            srbs_pkg::COND_PUSH:      take = flags.is_push;
            srbs_pkg::COND_FEW:       take = flags.few;
            srbs_pkg::COND_WALK_MORE: take = flags.walk_more;
            srbs_pkg::COND_NO_PAIR:   take = flags.no_pair;
            srbs_pkg::COND_DIV_MORE:  take = flags.div_more;
            srbs_pkg::COND_OUT_FREE:  take = flags.out_free;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + srbs_pkg::step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= srbs_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

[hdl/snapshot_ring_bracket_search_top.sv]
// Snapshot ring with bracket search: tick store, walk and divider datapath.
// Depends on srbs_pkg, srbs_useq and snapshot_ring_bracket_search_top_macros.svh.
//
// The input channel (s_valid/s_ready) carries one request: a push of a snapshot
// tick or a query for the pair of snapshots that brackets a render tick. The
// result channel (m_valid/m_ready) returns exactly one result per request, in
// order. One request is worked on at a time under control of a microcoded
// sequencer. A push writes the tick store and emits its result without a walk.
// A query with fewer than two snapshots emits a miss without a walk; otherwise
// the walk does one tick store read and one compare per snapshot visited, and a
// query that finds a bracket then runs the bit-serial restoring divider.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the block in its emit step only once a
// second result is ready. Reset empties the ring (count and head cleared) and
// needs no clearing pass; the tick store itself is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "snapshot_ring_bracket_search_top_macros.svh"
module snapshot_ring_bracket_search_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [srbs_pkg::TICK_W-1:0]       s_tick,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_pair_found,
    output logic [srbs_pkg::SLOT_W-1:0]            m_older_slot,
    output logic [srbs_pkg::SLOT_W-1:0]            m_newer_slot,
    output logic [srbs_pkg::FRAC_BITS-1:0]         m_fraction,
    output logic                                   m_latest_valid,
    output logic [srbs_pkg::SLOT_W-1:0]            m_latest_slot,
    output logic [srbs_pkg::COUNT_W-1:0]           m_stored_count
);

    srbs_pkg::ctrl_word_t  ctrl;
    srbs_pkg::cond_flags_t flags;

    logic [srbs_pkg::TICK_W-1:0]    tick_mem [srbs_pkg::DEPTH];

    logic [srbs_pkg::SLOT_W-1:0]    head_reg,     head_next;
    logic [srbs_pkg::COUNT_W-1:0]   count_reg,    count_next;
    logic                           push_reg,     push_next;
    logic                           have_old_reg, have_old_next;
    logic                           have_new_reg, have_new_next;
    logic                           m_valid_reg,  m_valid_next;

    logic [srbs_pkg::TICK_W-1:0]    tk_reg;
    logic [srbs_pkg::TICK_W-1:0]    rd_reg;
    logic [srbs_pkg::SLOT_W-1:0]    idx_reg;
    logic [srbs_pkg::COUNT_W-1:0]   left_reg;
    logic [srbs_pkg::SLOT_W-1:0]    old_slot_reg;
    logic [srbs_pkg::SLOT_W-1:0]    new_slot_reg;
    logic [srbs_pkg::TICK_W-1:0]    old_tick_reg;
    logic [srbs_pkg::TICK_W-1:0]    rem_reg;
    logic [srbs_pkg::TICK_W-1:0]    span_reg;
    logic [srbs_pkg::FRAC_BITS-1:0] quo_reg;
    logic [srbs_pkg::BITCNT_W-1:0]  bit_cnt_reg;

    logic                           tick_le;
    logic [srbs_pkg::TICK_W:0]      rem_shift;
    logic                           rem_ge;
    logic                           pair;
    logic                           emit;

    srbs_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign tick_le   = rd_reg <= tk_reg;
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, span_reg};
    assign pair      = have_old_reg & have_new_reg;
    assign emit      = (ctrl.act == srbs_pkg::ACT_EMIT) && (!m_valid_reg || m_ready);

    assign s_ready = ctrl.act == srbs_pkg::ACT_ACCEPT;
    assign m_valid = m_valid_reg;

    always_comb begin
        flags.no_req    = !s_valid;
        flags.is_push   = push_reg;
        flags.few       = count_reg < srbs_pkg::COUNT_W'(2);
        flags.walk_more = tick_le && (left_reg != srbs_pkg::COUNT_W'(1));
        flags.no_pair   = !pair;
        flags.div_more  = bit_cnt_reg != srbs_pkg::BITCNT_W'(1);
        flags.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        push_next     = push_reg;
        have_old_next = have_old_reg;
        have_new_next = have_new_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (ctrl.act)
            srbs_pkg::ACT_ACCEPT: begin
                if (s_valid) begin
                    push_next     = !s_req_type;
                    have_old_next = 1'b0;
                    have_new_next = 1'b0;
                end
            end
            srbs_pkg::ACT_COMPARE: begin
                if (tick_le) begin
                    have_old_next = 1'b1;
                end else begin
                    have_new_next = 1'b1;
                end
            end
            srbs_pkg::ACT_PUSH: begin
                head_next = head_reg + srbs_pkg::SLOT_W'(1);
                if (count_reg != srbs_pkg::COUNT_FULL) begin
                    count_next = count_reg + srbs_pkg::COUNT_W'(1);
                end
            end
            srbs_pkg::ACT_EMIT: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            push_reg     <= 1'b0;
            have_old_reg <= 1'b0;
            have_new_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            push_reg     <= push_next;
            have_old_reg <= have_old_next;
            have_new_reg <= have_new_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.act == srbs_pkg::ACT_PUSH) begin
            tick_mem[head_reg] <= tk_reg;
        end
        if (ctrl.act == srbs_pkg::ACT_READ) begin
            rd_reg <= tick_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.act)
            srbs_pkg::ACT_ACCEPT: begin
                if (s_valid) begin
                    tk_reg <= s_tick;
                end
            end
            srbs_pkg::ACT_WALK_INIT: begin
                idx_reg  <= head_reg - count_reg[srbs_pkg::SLOT_W-1:0];
                left_reg <= count_reg;
            end
            srbs_pkg::ACT_COMPARE: begin
                if (tick_le) begin
                    old_slot_reg <= idx_reg;
                    old_tick_reg <= rd_reg;
                end else begin
                    new_slot_reg <= idx_reg;
                end
                idx_reg  <= idx_reg + srbs_pkg::SLOT_W'(1);
                left_reg <= left_reg - srbs_pkg::COUNT_W'(1);
            end
            srbs_pkg::ACT_DIV_INIT: begin
                rem_reg     <= tk_reg - old_tick_reg;
                span_reg    <= rd_reg - old_tick_reg;
                quo_reg     <= '0;
                bit_cnt_reg <= srbs_pkg::BITCNT_W'(srbs_pkg::FRAC_BITS);
            end
            srbs_pkg::ACT_DIV_STEP: begin
                if (rem_ge) begin
                    rem_reg <= srbs_pkg::TICK_W'(rem_shift - {1'b0, span_reg});
                end else begin
                    rem_reg <= rem_shift[srbs_pkg::TICK_W-1:0];
                end
                quo_reg     <= {quo_reg[srbs_pkg::FRAC_BITS-2:0], rem_ge};
                bit_cnt_reg <= bit_cnt_reg - srbs_pkg::BITCNT_W'(1);
            end
            srbs_pkg::ACT_EMIT: begin
                if (emit) begin
                    m_pair_found   <= pair;
                    m_older_slot   <= pair ? old_slot_reg : '0;
                    m_newer_slot   <= pair ? new_slot_reg : '0;
                    m_fraction     <= pair ? quo_reg : '0;
                    m_latest_valid <= count_reg != '0;
                    m_latest_slot  <= (count_reg != '0) ? head_reg - srbs_pkg::SLOT_W'(1) : '0;
                    m_stored_count <= count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    `SRBS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= srbs_pkg::COUNT_FULL)
    `SRBS_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SRBS_ASSERT_SAME(a_pair_slots, aclk, aresetn, m_valid && m_pair_found, m_older_slot != m_newer_slot)
    `SRBS_ASSERT_SAME(a_miss_zero, aclk, aresetn, m_valid && !m_pair_found, m_fraction == '0 && m_older_slot == '0 && m_newer_slot == '0)
    `SRBS_ASSERT_SAME(a_latest, aclk, aresetn, m_valid, m_latest_valid == (m_stored_count != '0))

endmodule
`default_nettype wire
